/* hw/rtl/csq_pkg.sv */
// shared types and constants for the consecutive score qualifier
`default_nettype none

package csq_pkg;

  localparam int unsigned ScoreWidth   = 16;
  localparam int unsigned RunWidth     = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 8;

  typedef enum logic [1:0] {
    CLS_UNCERTAIN = 2'd0,
    CLS_POSITIVE  = 2'd1,
    CLS_NEGATIVE  = 2'd2
  } class_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_POS_LIMIT  = 3'd0,
    REG_NEG_LIMIT  = 3'd1,
    REG_POS_RUN    = 3'd2,
    REG_NEG_RUN    = 3'd3,
    REG_UNCERT_RUN = 3'd4
  } cfg_idx_e;

  // score thresholds handed to the classifier
  typedef struct packed {
    logic signed [ScoreWidth-1:0] pos_limit;
    logic signed [ScoreWidth-1:0] neg_limit;
  } score_limits_t;

  localparam logic [RunWidth-1:0] RunMax      = {RunWidth{1'b1}};
  localparam logic [RunWidth-1:0] RunOne      = RunWidth'(1);
  localparam logic [RunWidth-1:0] RunNeededRst = RunWidth'(1);

endpackage

`default_nettype wire

/* hw/rtl/csq_classifier.sv */
// sorts one score into positive, negative or uncertain
`default_nettype none

module csq_classifier (
  input  wire logic signed [csq_pkg::ScoreWidth-1:0] score_i,
  input  wire logic                                  score_valid_i,
  input  wire csq_pkg::score_limits_t                limits_i,
  output csq_pkg::class_e                            class_o
);

  // positive test wins when the limits overlap
  always_comb begin
    if (score_valid_i && (score_i >= limits_i.pos_limit)) begin
      class_o = csq_pkg::CLS_POSITIVE;
    end else if (score_valid_i && (score_i < limits_i.neg_limit)) begin
      class_o = csq_pkg::CLS_NEGATIVE;
    end else begin
      class_o = csq_pkg::CLS_UNCERTAIN;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/consecutive_score_qualifier.sv */
// top level of the consecutive score qualifier (debounce filter for scores)
`default_nettype none

// Debounce filter for a stream of inference scores. Each input item carries a
// signed 16-bit score in tdata and a valid flag in tuser. A valid score at or
// above the positive limit is positive, else a valid score below the negative
// limit is negative, else the item is uncertain. The block counts how many
// items in a row had the same class (the count saturates at 65535); once that
// run reaches the run length programmed for its class, the held verdict
// switches to that class. Every input item gives exactly one output item that
// carries the held verdict after this update (0 uncertain, 1 positive,
// 2 negative). Throughput is one item per clock unless the output stalls. An
// item passes the input register, then the result register; the run counter
// and verdict are updated as it moves from the first to the second. The output
// stage's tready is passed back combinationally to the input side, so a stall
// on the output side holds both registers without losing an item. The five
// registers are written through the cfg port (index 0..4, other indexes are
// ignored) and must only be written while no item is in flight.

module consecutive_score_qualifier (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration write channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [csq_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  wire logic [csq_pkg::CfgDataWidth-1:0]      cfg_data_i,
  // input stream
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  wire logic [csq_pkg::InDataWidth-1:0]       s_axis_tdata_i,  // [15:0] score
  input  wire logic [0:0]                            s_axis_tuser_i,  // [0] score_valid
  // result stream
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  output logic [csq_pkg::OutDataWidth-1:0]           m_axis_tdata_o   // [1:0] verdict
);

  // configuration registers
  csq_pkg::score_limits_t              limits_q;
  logic [csq_pkg::RunWidth-1:0]        pos_run_q;
  logic [csq_pkg::RunWidth-1:0]        neg_run_q;
  logic [csq_pkg::RunWidth-1:0]        unc_run_q;

  // input register
  logic                                in_valid_q;
  logic signed [csq_pkg::ScoreWidth-1:0] score_q;
  logic                                score_flag_q;

  // filter state
  csq_pkg::class_e                     run_class_q, run_class_d;
  logic [csq_pkg::RunWidth-1:0]        run_len_q, run_len_d;
  csq_pkg::class_e                     held_q, held_d;

  // result register
  logic                                out_valid_q;
  csq_pkg::class_e                     out_verdict_q;

  csq_pkg::class_e                     item_class;
  logic [csq_pkg::RunWidth-1:0]        run_needed;
  logic                                out_load;
  logic                                advance;

  // config port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.pos_limit <= '0;
      limits_q.neg_limit <= '0;
      pos_run_q          <= csq_pkg::RunNeededRst;
      neg_run_q          <= csq_pkg::RunNeededRst;
      unc_run_q          <= csq_pkg::RunNeededRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csq_pkg::REG_POS_LIMIT:  limits_q.pos_limit <= cfg_data_i;
        csq_pkg::REG_NEG_LIMIT:  limits_q.neg_limit <= cfg_data_i;
        csq_pkg::REG_POS_RUN:    pos_run_q          <= cfg_data_i;
        csq_pkg::REG_NEG_RUN:    neg_run_q          <= cfg_data_i;
        csq_pkg::REG_UNCERT_RUN: unc_run_q          <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // handshake: result register frees up when empty or taken this cycle,
  // the input register moves on whenever the result register can load
  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_load;
  assign s_axis_tready_o = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      score_q      <= s_axis_tdata_i;
      score_flag_q <= s_axis_tuser_i[0];
    end
  end

  csq_classifier u_classifier (
    .score_i       (score_q),
    .score_valid_i (score_flag_q),
    .limits_i      (limits_q),
    .class_o       (item_class)
  );

  // run tracking: extend the run (saturating) or start a new one
  always_comb begin
    if (item_class == run_class_q) begin
      run_class_d = run_class_q;
      run_len_d   = (run_len_q == csq_pkg::RunMax) ? run_len_q
                                                   : run_len_q + csq_pkg::RunOne;
    end else begin
      run_class_d = item_class;
      run_len_d   = csq_pkg::RunOne;
    end

    case (run_class_d)
      csq_pkg::CLS_POSITIVE: run_needed = pos_run_q;
      csq_pkg::CLS_NEGATIVE: run_needed = neg_run_q;
      default:               run_needed = unc_run_q;
    endcase

    // run long enough: verdict follows the run
    held_d = (run_len_d >= run_needed) ? run_class_d : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_class_q <= csq_pkg::CLS_UNCERTAIN;
      run_len_q   <= '0;
      held_q      <= csq_pkg::CLS_UNCERTAIN;
    end else if (advance) begin
      run_class_q <= run_class_d;
      run_len_q   <= run_len_d;
      held_q      <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_verdict_q <= held_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(csq_pkg::OutDataWidth-2){1'b0}}, out_verdict_q};

`ifndef ASSERT_OFF
  // every processed item leaves a run of at least one
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (run_len_q != '0))
    else $error("run length is zero after an item");

  // same class below saturation extends the run by one
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (item_class == run_class_q) && (run_len_q != csq_pkg::RunMax))
      |=> (run_len_q == $past(run_len_q) + csq_pkg::RunOne))
    else $error("run length did not step");

  // result register carries the verdict just committed
  a_out_matches_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (out_verdict_q == held_q)))
    else $error("result verdict differs from held verdict");

  // a stalled item in the input register is kept
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> (in_valid_q && $stable(score_q)))
    else $error("stalled input item lost");
`endif

endmodule

`default_nettype wire

/* dv/consecutive_score_qualifier_tb.sv */
// self-checking testbench for the consecutive score qualifier debounce filter
`default_nettype none

module consecutive_score_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // score range and run bookkeeping
  localparam int ScoreMax      = 2 ** (csq_pkg::ScoreWidth - 1) - 1;
  localparam int ScoreMin      = -(2 ** (csq_pkg::ScoreWidth - 1));
  localparam int VerdictWidth  = 2;
  localparam int RandomItems   = 1950;
  localparam int RandomPhases  = 8;
  localparam int LongRun       = 24;   // positive run that stays below a full-range threshold
  localparam int DrainLimit    = 400;  // cycles allowed for results to come out after the last item
  localparam int SettleCycles  = 4;    // two-stage pipe plus margin before touching registers
  localparam int MaxPrinted    = 40;

  // one input item as the filter sees it
  typedef struct packed {
    logic signed [csq_pkg::ScoreWidth-1:0] score;
    logic                                  score_valid;
  } score_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration channel
  logic                             cfg_valid = 1'b0;
  logic [csq_pkg::CfgIdxWidth-1:0]  cfg_index = csq_pkg::REG_POS_LIMIT;
  logic [csq_pkg::CfgDataWidth-1:0] cfg_data = '0;
  logic                             cfg_ready;

  // score stream into the block
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [csq_pkg::InDataWidth-1:0] in_tdata = '0;   // [15:0] score
  logic [0:0]                      in_tuser = '0;   // [0] score_valid

  // verdict stream out of the block
  logic                             res_tvalid;
  logic                             res_tready = 1'b1;
  logic [csq_pkg::OutDataWidth-1:0] res_tdata;      // [1:0] verdict

  consecutive_score_qualifier i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_tvalid),
    .s_axis_tready_o (in_tready),
    .s_axis_tdata_i  (in_tdata),
    .s_axis_tuser_i  (in_tuser),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .m_axis_tdata_o  (res_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the filter registers, updated when a write handshake completes
  logic signed [csq_pkg::ScoreWidth-1:0] pos_limit = '0;
  logic signed [csq_pkg::ScoreWidth-1:0] neg_limit = '0;
  logic [csq_pkg::RunWidth-1:0]          pos_run_need = csq_pkg::RunNeededRst;
  logic [csq_pkg::RunWidth-1:0]          neg_run_need = csq_pkg::RunNeededRst;
  logic [csq_pkg::RunWidth-1:0]          unc_run_need = csq_pkg::RunNeededRst;

  // predicted filter state
  csq_pkg::class_e              cur_class = csq_pkg::CLS_UNCERTAIN;
  logic [csq_pkg::RunWidth-1:0] cur_run = '0;
  csq_pkg::class_e              held_class = csq_pkg::CLS_UNCERTAIN;

  score_item_t     pending_scores[$];   // items not yet offered to the block
  csq_pkg::class_e verdicts_due[$];     // verdicts owed by the block, oldest first

  int  items_queued = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  settings_used = 0;
  int  mismatches = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  bit  idle_on = 1'b1;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("mismatch at %0d ns: %s", $time, what);
  endtask

  // classify one score, advance the run and return the held verdict after the update
  function automatic csq_pkg::class_e qualify_score(
      logic signed [csq_pkg::ScoreWidth-1:0] score, logic score_valid);
    csq_pkg::class_e              cls;
    logic [csq_pkg::RunWidth-1:0] needed;
    cls = csq_pkg::CLS_UNCERTAIN;
    // positive wins when the two limits overlap
    if (score_valid && score >= pos_limit) cls = csq_pkg::CLS_POSITIVE;
    else if (score_valid && score < neg_limit) cls = csq_pkg::CLS_NEGATIVE;
    if (cls == cur_class) begin
      if (cur_run != csq_pkg::RunMax) cur_run++;
    end else begin
      cur_class = cls;
      cur_run   = csq_pkg::RunOne;
    end
    case (cur_class)
      csq_pkg::CLS_POSITIVE: needed = pos_run_need;
      csq_pkg::CLS_NEGATIVE: needed = neg_run_need;
      default:               needed = unc_run_need;
    endcase
    if (cur_run >= needed) held_class = cur_class;
    return held_class;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // item driver: a new item goes out once the current one is taken, with random gaps
  always @(posedge clk) begin : score_driver
    score_item_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        verdicts_due.push_back(qualify_score(in_tdata, in_tuser[0]));
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_scores.size() > 0) begin
          nxt = pending_scores.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.score;
          in_tuser  <= nxt.score_valid;
          if (idle_on && $urandom_range(0, 15) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor: checks every result against the oldest owed verdict, stalls at random
  always @(posedge clk) begin : verdict_monitor
    csq_pkg::class_e want;
    if (rst_n) begin
      if (res_tvalid && res_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("verdict item 0x%0h with nothing owed", res_tdata));
        end else begin
          want = verdicts_due.pop_front();
          results_checked++;
          if (res_tdata[VerdictWidth-1:0] !== want)
            report_mismatch($sformatf("verdict %0d, predicted %s",
                                      res_tdata[VerdictWidth-1:0], want.name()));
          if (res_tdata[csq_pkg::OutDataWidth-1:VerdictWidth] !== '0)
            report_mismatch($sformatf("nonzero pad bits in verdict item 0x%0h", res_tdata));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        res_tready <= 1'b0;
      end else begin
        res_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 15) == 0) sink_gap = $urandom_range(1, 13);
      end
    end
  end

  task automatic write_reg(logic [csq_pkg::CfgIdxWidth-1:0] idx,
                           logic [csq_pkg::CfgDataWidth-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // indexes past the last register are dropped by the block
    case (idx)
      csq_pkg::REG_POS_LIMIT:  pos_limit    = val;
      csq_pkg::REG_NEG_LIMIT:  neg_limit    = val;
      csq_pkg::REG_POS_RUN:    pos_run_need = val;
      csq_pkg::REG_NEG_RUN:    neg_run_need = val;
      csq_pkg::REG_UNCERT_RUN: unc_run_need = val;
      default: ;
    endcase
  endtask

  task automatic program_filter(int pl, int nl, int pn, int nn, int un);
    if ($urandom_range(0, 2) == 0)
      write_reg(csq_pkg::CfgIdxWidth'($urandom_range(int'(csq_pkg::REG_UNCERT_RUN) + 1,
                                                     (1 << csq_pkg::CfgIdxWidth) - 1)),
                csq_pkg::CfgDataWidth'($urandom));
    write_reg(csq_pkg::REG_POS_LIMIT, csq_pkg::CfgDataWidth'(pl));
    write_reg(csq_pkg::REG_NEG_LIMIT, csq_pkg::CfgDataWidth'(nl));
    write_reg(csq_pkg::REG_POS_RUN, csq_pkg::CfgDataWidth'(pn));
    write_reg(csq_pkg::REG_NEG_RUN, csq_pkg::CfgDataWidth'(nn));
    write_reg(csq_pkg::REG_UNCERT_RUN, csq_pkg::CfgDataWidth'(un));
    settings_used++;
  endtask

  task automatic queue_score(int score, bit score_valid);
    score_item_t itm;
    itm.score       = csq_pkg::ScoreWidth'(score);
    itm.score_valid = score_valid;
    pending_scores.push_back(itm);
    items_queued++;
  endtask

  // pick a score that lands in the wanted class under the current limits
  task automatic queue_class_item(csq_pkg::class_e cls);
    int neg_top;
    neg_top = ((int'(neg_limit) < int'(pos_limit)) ? int'(neg_limit) : int'(pos_limit)) - 1;
    case (cls)
      csq_pkg::CLS_POSITIVE: begin
        queue_score(rand_between(int'(pos_limit), ScoreMax), 1'b1);
      end
      csq_pkg::CLS_NEGATIVE: begin
        // the negative band is empty when either limit sits at the bottom
        if (neg_top >= ScoreMin) queue_score(rand_between(ScoreMin, neg_top), 1'b1);
        else queue_score(int'($urandom), 1'b0);
      end
      default: begin
        if (int'(neg_limit) < int'(pos_limit) && $urandom_range(0, 1) == 1)
          queue_score(rand_between(int'(neg_limit), int'(pos_limit) - 1), 1'b1);
        else
          queue_score(int'($urandom), 1'b0);
      end
    endcase
  endtask

  // wait until every item is taken and every verdict is back, then let the pipe settle
  task automatic wait_drain();
    int spins;
    spins = 0;
    while (items_accepted != items_queued) @(negedge clk);
    while (verdicts_due.size() != 0 && spins < DrainLimit) begin
      @(negedge clk);
      spins++;
    end
    if (verdicts_due.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
      verdicts_due.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // mostly runs of one class with random length, some items fully random
  task automatic run_random_phase(int n);
    int              left;
    int              len;
    csq_pkg::class_e cls;
    @(negedge clk);
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_score(int'($urandom), 1'($urandom_range(0, 1)));
        left--;
      end else begin
        cls = csq_pkg::class_e'($urandom_range(csq_pkg::CLS_UNCERTAIN, csq_pkg::CLS_NEGATIVE));
        len = $urandom_range(1, 8);
        repeat (len) queue_class_item(cls);
        left -= len;
      end
    end
    wait_drain();
  endtask

  initial begin : stimulus
    int near;
    near = 200;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: both limits zero, every run needed one
    queue_score(ScoreMin, 1'b0);    // uncertain first item extends the reset run
    queue_score(ScoreMax, 1'b1);
    queue_score(0, 1'b1);           // exactly at the positive limit
    queue_score(-1, 1'b1);
    queue_score(ScoreMin, 1'b1);
    queue_score(ScoreMax, 1'b0);    // invalid flag wins over a high score
    queue_score(0, 1'b0);
    wait_drain();
    settings_used++;

    // writes past the register file must not disturb anything
    for (int i = int'(csq_pkg::REG_UNCERT_RUN) + 1; i < (1 << csq_pkg::CfgIdxWidth); i++)
      write_reg(csq_pkg::CfgIdxWidth'(i), csq_pkg::CfgDataWidth'($urandom));

    // overlapping limits, positive needs no run at all
    program_filter(-100, 100, 0, 3, 2);
    @(negedge clk);
    queue_score(-100, 1'b1);        // passes both tests, counts positive
    queue_score(99, 1'b1);
    queue_score(-101, 1'b1);
    queue_score(ScoreMin, 1'b1);
    queue_score(-200, 1'b1);        // third negative in a row flips the verdict
    queue_score(5, 1'b0);
    queue_score(5, 1'b0);
    queue_score(-101, 1'b1);
    queue_score(ScoreMax, 1'b1);    // zero run needed flips on the first positive
    wait_drain();

    // long positive run against the full-range threshold: verdict stays negative
    program_filter(0, 0, int'(csq_pkg::RunMax), 1, 1);
    @(negedge clk);
    queue_score(-5, 1'b1);
    repeat (LongRun) queue_class_item(csq_pkg::CLS_POSITIVE);
    wait_drain();

    for (int k = 0; k < RandomPhases; k++) begin
      // the last stretch runs with both sides always ready
      idle_on = (k != RandomPhases - 1);
      case (k)
        0: program_filter(rand_between(ScoreMin, ScoreMax), rand_between(ScoreMin, ScoreMax),
                          rand_between(0, 5), rand_between(0, 5), rand_between(0, 5));
        1: program_filter(ScoreMin, ScoreMax, rand_between(1, 6), rand_between(1, 6),
                          rand_between(1, 6));
        2: program_filter(ScoreMax, ScoreMin, rand_between(1, 4), rand_between(1, 4),
                          rand_between(1, 4));
        3: program_filter(rand_between(-near, near), rand_between(-near, near), 0, 0, 0);
        4: program_filter(rand_between(-near, near), rand_between(-near, near), 0,
                          int'(csq_pkg::RunMax), int'(csq_pkg::RunMax));
        default: program_filter(rand_between(-near, near), rand_between(-near, near),
                                rand_between(1, 6), rand_between(1, 6), rand_between(1, 6));
      endcase
      run_random_phase(RandomItems / RandomPhases);
    end

    repeat (4 * SettleCycles) @(posedge clk);
    $display("covered %0d score items and checked %0d verdicts over %0d filter settings",
             items_accepted, results_checked, settings_used);
    $display("incl. overlapping and extreme limits, zero and full-range run thresholds");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog sized for the worst case of every item meeting the longest gaps on both sides
  initial begin : watchdog
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
